FILE: design/frsr_pkg.sv
// Shared widths, defaults and register codes of the frequency and spatial RRIP replacement block.
package frsr_pkg;

    localparam int TAG_W    = 58;
    localparam int SIDX_W   = 11;
    localparam int WIDX_W   = 4;
    localparam int MASK_W   = 16;
    localparam int VICT_W   = 4;
    localparam int CFG_W    = 3;
    localparam int IN_W     = 96;
    localparam int OUT_W    = 8;
    localparam int USER_W   = 2;
    localparam int PADDR_W  = 3;

    localparam int NUM_SETS_DEF     = 2048;
    localparam int NUM_WAYS_DEF     = 16;
    localparam int FREQ_ENTRIES_DEF = 8;
    localparam int FREQ_LIMIT_DEF   = 7;
    localparam int RRPV_WIDTH_DEF   = 2;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 3'd2;
    localparam logic [CFG_W-1:0] THRESH_RESET = 3'd2;

    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    localparam logic FUNC_VICTIM = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

endpackage

FILE: design/frsr_victim_scan.sv
// Way-serial scan that picks a victim from the stored per-way state of one set.
module frsr_victim_scan
    import frsr_pkg::*;
#(
    parameter int NUM_WAYS   = NUM_WAYS_DEF,
    parameter int RRPV_WIDTH = RRPV_WIDTH_DEF,
    parameter int FREQ_W     = 3,
    parameter int WAY_W      = 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [NUM_WAYS-1:0][RRPV_WIDTH-1:0]   rrpv,
    input  logic [NUM_WAYS-1:0][FREQ_W-1:0]       freq,
    input  logic [NUM_WAYS-1:0][WAY_W-1:0]        pos,
    input  logic [NUM_WAYS-1:0]                   sp,
    output logic                                  done,
    output logic [WAY_W-1:0]                      way
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [WAY_W-1:0]      cnt_reg;
    logic                  fb_reg, fc_reg;
    logic [WAY_W-1:0]      bb_reg, bpos_reg, cb_reg, cpos_reg;
    logic [RRPV_WIDTH-1:0] maxr_reg;
    logic [FREQ_W-1:0]     minf_reg;

    logic [RRPV_WIDTH-1:0] r_cur;
    logic [FREQ_W-1:0]     f_cur;
    logic [WAY_W-1:0]      p_cur;
    logic                  s_cur;
    logic                  take_b, take_c;

    always_comb begin
        r_cur  = rrpv[cnt_reg];
        f_cur  = freq[cnt_reg];
        p_cur  = pos[cnt_reg];
        s_cur  = sp[cnt_reg];
        take_b = (f_cur == '0) && !s_cur && (!fb_reg || p_cur > bpos_reg);
        take_c = (r_cur >= maxr_reg) && (!fc_reg || f_cur < minf_reg ||
                 (f_cur == minf_reg && p_cur > cpos_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == WAY_W'(NUM_WAYS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg  <= '0;
            fb_reg   <= 1'b0;
            fc_reg   <= 1'b0;
            bb_reg   <= '0;
            bpos_reg <= '0;
            cb_reg   <= '0;
            cpos_reg <= '0;
            maxr_reg <= '0;
            minf_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + WAY_W'(1);
            if (take_b) begin
                fb_reg   <= 1'b1;
                bb_reg   <= cnt_reg;
                bpos_reg <= p_cur;
            end
            if (take_c) begin
                fc_reg   <= 1'b1;
                cb_reg   <= cnt_reg;
                cpos_reg <= p_cur;
                maxr_reg <= r_cur;
                minf_reg <= f_cur;
            end
        end
    end

    assign done = done_reg;
    assign way  = fb_reg ? bb_reg : cb_reg;

endmodule

FILE: design/freq_spatial_rrip_replacement.sv
// Top level of the frequency, spatial reuse, RRIP and LRU cache replacement block.
//
//  Channel  | Direction | Moves
//  s_       | in        | victim request or state update word
//  m_       | out       | victim way word
//  APB      | in/out    | spatial_half_window (0x0), retain_freq_threshold (0x4)
//
// After reset a clearing pass writes every set, with no word taken.
// An update passes through set wrap check with memory read, frequency table step, write back.
// A victim request with an invalid way skips the scan; otherwise the way-serial scan unit
// checks the ways, one way per cycle, before the result is ready.
// A set index at or above NUM_SETS is reduced by repeated subtraction of NUM_SETS.
// A result waiting on m_tready stalls the block, input included, only once the next victim
// result is ready behind it.
module freq_spatial_rrip_replacement
    import frsr_pkg::*;
#(
    parameter int NUM_SETS     = NUM_SETS_DEF,
    parameter int NUM_WAYS     = NUM_WAYS_DEF,
    parameter int FREQ_ENTRIES = FREQ_ENTRIES_DEF,
    parameter int FREQ_LIMIT   = FREQ_LIMIT_DEF,
    parameter int RRPV_WIDTH   = RRPV_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // set_index[10:0], way_index[14:11], valid_mask[30:15], line_address[88:31], zeros
    input  logic [IN_W-1:0]    s_tdata,
    // func[0], hit_flag[1]
    input  logic [USER_W-1:0]  s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // victim_way[3:0], zeros
    output logic [OUT_W-1:0]   m_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int FREQ_W = $clog2(FREQ_LIMIT + 1);
    localparam int PTR_W  = (FREQ_ENTRIES > 1) ? $clog2(FREQ_ENTRIES) : 1;
    localparam int THW    = (FREQ_W > CFG_W) ? FREQ_W : CFG_W;
    localparam int MW     = (NUM_WAYS < MASK_W) ? NUM_WAYS : MASK_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WRAP  = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_APPLY = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    typedef struct packed {
        logic [NUM_WAYS-1:0][RRPV_WIDTH-1:0] rrpv;
        logic [NUM_WAYS-1:0][FREQ_W-1:0]     freq;
        logic [NUM_WAYS-1:0][WAY_W-1:0]      pos;
        logic [NUM_WAYS-1:0]                 sp;
    } way_row_t;

    typedef struct packed {
        logic [FREQ_ENTRIES-1:0][TAG_W-1:0]  tag;
        logic [FREQ_ENTRIES-1:0][FREQ_W-1:0] cnt;
        logic [FREQ_ENTRIES-1:0]             vld;
        logic [PTR_W-1:0]                    ptr;
        logic [TAG_W-1:0]                    last;
    } freq_row_t;

    way_row_t  way_mem  [NUM_SETS];
    freq_row_t freq_mem [NUM_SETS];
    way_row_t  way_rd;
    freq_row_t freq_rd;

    logic [2:0]        state_reg, state_next;
    logic [SET_W-1:0]  clr_reg;
    logic [SIDX_W-1:0] set_reg;
    logic [WIDX_W-1:0] way_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic              func_reg, hit_reg;
    logic [CFG_W-1:0]  window_reg, thresh_reg;
    logic              m_valid_reg;
    logic [VICT_W-1:0] m_way_reg;
    logic [VICT_W-1:0] victim_reg;
    freq_row_t         frow_reg;
    logic [FREQ_W-1:0] fcnt_reg;
    logic              sp_reg;

    logic              set_ok, way_ok, mem_re, mem_we, inv_found, scan_start, scan_done;
    logic [SET_W-1:0]  waddr;
    logic [VICT_W-1:0] inv_way;
    logic [WAY_W-1:0]  scan_way, ws;
    way_row_t          way_wdata, way_clr, way_upd;
    freq_row_t         freq_wdata, frow_next;
    logic [FREQ_W-1:0] fcnt_next, cnt_old;
    logic              sp_next, match_any;
    logic [PTR_W-1:0]  match_idx;
    logic [TAG_W-1:0]  tag_gap;
    logic              cfg_wr;

    assign set_ok = 32'(set_reg) < NUM_SETS;
    assign way_ok = 32'(way_reg) < NUM_WAYS;
    assign ws     = WAY_W'(way_reg);

    always_comb begin
        inv_found = 1'b0;
        inv_way   = '0;
        for (int w = MW - 1; w >= 0; w--) begin
            if (!mask_reg[w]) begin
                inv_found = 1'b1;
                inv_way   = VICT_W'(w);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        mem_re     = 1'b0;
        scan_start = 1'b0;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == SET_W'(NUM_SETS - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_WRAP;
            ST_WRAP: begin
                if (set_ok) begin
                    if (func_reg == FUNC_UPDATE && !way_ok) begin
                        state_next = ST_IDLE;
                    end else begin
                        mem_re     = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                if (func_reg == FUNC_UPDATE) begin
                    state_next = ST_APPLY;
                end else if (inv_found) begin
                    state_next = ST_DONE;
                end else begin
                    scan_start = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:  if (scan_done) state_next = ST_DONE;
            ST_APPLY: state_next = ST_IDLE;
            ST_DONE:  if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + SET_W'(1);
            if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            set_reg  <= s_tdata[10:0];
            way_reg  <= s_tdata[14:11];
            mask_reg <= s_tdata[30:15];
            tag_reg  <= s_tdata[88:31];
            func_reg <= s_tuser[0];
            hit_reg  <= s_tuser[1];
        end else if (state_reg == ST_WRAP && !set_ok) begin
            set_reg <= set_reg - SIDX_W'(NUM_SETS);
        end
        if (state_reg == ST_LOAD) begin
            victim_reg <= inv_way;
            frow_reg   <= frow_next;
            fcnt_reg   <= fcnt_next;
            sp_reg     <= sp_next;
        end else if (state_reg == ST_SCAN && scan_done) begin
            victim_reg <= VICT_W'(scan_way);
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) m_way_reg <= victim_reg;
    end

    always_comb begin
        match_any = 1'b0;
        match_idx = '0;
        for (int e = FREQ_ENTRIES - 1; e >= 0; e--) begin
            if (freq_rd.vld[e] && freq_rd.tag[e] == tag_reg) begin
                match_any = 1'b1;
                match_idx = PTR_W'(e);
            end
        end
        cnt_old   = freq_rd.cnt[match_idx];
        frow_next = freq_rd;
        if (match_any) begin
            if (!hit_reg) fcnt_next = FREQ_W'(1);
            else if (cnt_old < FREQ_W'(FREQ_LIMIT)) fcnt_next = cnt_old + FREQ_W'(1);
            else fcnt_next = cnt_old;
            frow_next.cnt[match_idx] = fcnt_next;
        end else begin
            fcnt_next                  = FREQ_W'(1);
            frow_next.tag[freq_rd.ptr] = tag_reg;
            frow_next.cnt[freq_rd.ptr] = FREQ_W'(1);
            frow_next.vld[freq_rd.ptr] = 1'b1;
            frow_next.ptr = (freq_rd.ptr == PTR_W'(FREQ_ENTRIES - 1)) ? '0
                          : freq_rd.ptr + PTR_W'(1);
        end
        if (!hit_reg) frow_next.last = tag_reg;
        tag_gap = (tag_reg > freq_rd.last) ? tag_reg - freq_rd.last
                                           : freq_rd.last - tag_reg;
        sp_next = (freq_rd.last != '0) && (tag_gap != '0) && (tag_gap <= TAG_W'(window_reg));
    end

    always_comb begin
        way_upd = way_rd;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (way_rd.pos[w] < way_rd.pos[ws]) way_upd.pos[w] = way_rd.pos[w] + WAY_W'(1);
        end
        way_upd.pos[ws]  = '0;
        way_upd.freq[ws] = fcnt_reg;
        way_upd.sp[ws]   = sp_reg;
        if (hit_reg || THW'(fcnt_reg) >= THW'(thresh_reg) || sp_reg) begin
            way_upd.rrpv[ws] = '0;
        end else begin
            way_upd.rrpv[ws] = '1;
        end
        way_clr = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            way_clr.rrpv[w] = '1;
            way_clr.pos[w]  = WAY_W'(w);
        end
    end

    assign mem_we     = (state_reg == ST_CLEAR) || (state_reg == ST_APPLY);
    assign waddr      = (state_reg == ST_CLEAR) ? clr_reg : SET_W'(set_reg);
    assign way_wdata  = (state_reg == ST_CLEAR) ? way_clr : way_upd;
    assign freq_wdata = (state_reg == ST_CLEAR) ? freq_row_t'('0) : frow_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            way_mem[waddr]  <= way_wdata;
            freq_mem[waddr] <= freq_wdata;
        end
        if (mem_re) begin
            way_rd  <= way_mem[SET_W'(set_reg)];
            freq_rd <= freq_mem[SET_W'(set_reg)];
        end
    end

    frsr_victim_scan #(
        .NUM_WAYS   (NUM_WAYS),
        .RRPV_WIDTH (RRPV_WIDTH),
        .FREQ_W     (FREQ_W),
        .WAY_W      (WAY_W)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scan_start),
        .rrpv    (way_rd.rrpv),
        .freq    (way_rd.freq),
        .pos     (way_rd.pos),
        .sp      (way_rd.sp),
        .done    (scan_done),
        .way     (scan_way)
    );

    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            thresh_reg <= THRESH_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WINDOW) window_reg <= pwdata[CFG_W-1:0];
            else thresh_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata   = (paddr[2] == REG_WINDOW) ? 32'(window_reg) : 32'(thresh_reg);
    assign pready   = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'(m_way_reg);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input taken straight after reset");

    a_done_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> ($past(state_reg) == ST_SCAN ||
        $past(state_reg) == ST_LOAD || $past(state_reg) == ST_DONE))
        else $error("result stage entered without a victim choice");

    a_no_write_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |-> !mem_we)
        else $error("memory read and write in the same cycle");

endmodule

FILE: verif/freq_spatial_rrip_replacement_tb.sv
// Self-checking testbench for the frequency, spatial reuse, RRIP and LRU replacement block.
`timescale 1ns / 1ps

module freq_spatial_rrip_replacement_tb;
    import frsr_pkg::*;

    localparam int SETS = NUM_SETS_DEF;
    localparam int WAYS = NUM_WAYS_DEF;
    localparam int FENT = FREQ_ENTRIES_DEF;
    localparam int FLIM = FREQ_LIMIT_DEF;
    localparam logic [1:0] RRPV_TOP = 2'd3;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic              func;
        logic [SIDX_W-1:0] set_index;
        logic [WIDX_W-1:0] way_index;
        logic [MASK_W-1:0] valid_mask;
        logic [TAG_W-1:0]  line_address;
        logic              hit_flag;
    } access_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata = '0;
    logic [USER_W-1:0]  s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    freq_spatial_rrip_replacement DUT (.*);

    // Shadow copy of the replacement state.
    logic [1:0]       rrpv [SETS][WAYS];
    logic [2:0]       wfreq [SETS][WAYS];
    logic [3:0]       rpos [SETS][WAYS];
    logic             smark [SETS][WAYS];
    logic [TAG_W-1:0] ftag [SETS][FENT];
    logic [2:0]       fcnt [SETS][FENT];
    logic             fval [SETS][FENT];
    logic [2:0]       fptr [SETS];
    logic [TAG_W-1:0] last_miss [SETS];
    logic [2:0]       half_window, retain_thresh;

    access_t      pending_words [$];
    logic [3:0]   expected_ways [$];
    int           errors = 0;
    int           sent = 0, victims_seen = 0;
    bit           hold_off = 1'b0;
    bit           offer_open = 1'b0;
    int           burst_left = 0, gap_left = 0;
    int           idle_cycles = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic logic [3:0] choose_victim(input int s, input logic [15:0] mask);
        logic [3:0] best;
        logic [3:0] best_pos;
        logic [1:0] max_r;
        int         min_f;
        bit         found;
        best = 0; best_pos = 0; max_r = 0; min_f = FLIM + 1; found = 0;
        for (int w = 0; w < WAYS; w++)
            if (!mask[w]) return w[3:0];
        for (int w = 0; w < WAYS; w++)
            if (wfreq[s][w] == 0 && !smark[s][w] && (!found || rpos[s][w] > best_pos)) begin
                best = w[3:0]; best_pos = rpos[s][w]; found = 1;
            end
        if (found) return best;
        best_pos = 0;
        for (int w = 0; w < WAYS; w++)
            if (rrpv[s][w] >= max_r && (!found || wfreq[s][w] < min_f ||
                    (wfreq[s][w] == min_f && rpos[s][w] > best_pos))) begin
                best = w[3:0]; max_r = rrpv[s][w]; min_f = wfreq[s][w];
                best_pos = rpos[s][w]; found = 1;
            end
        return best;
    endfunction

    function automatic logic [2:0] count_tag(input int s, input logic [TAG_W-1:0] tag,
                                             input logic hit);
        for (int e = 0; e < FENT; e++)
            if (fval[s][e] && ftag[s][e] == tag) begin
                if (!hit) fcnt[s][e] = 1;
                else if (fcnt[s][e] < FLIM) fcnt[s][e]++;
                return fcnt[s][e];
            end
        ftag[s][fptr[s]] = tag;
        fcnt[s][fptr[s]] = 1;
        fval[s][fptr[s]] = 1;
        fptr[s] = fptr[s] + 3'd1;
        return 3'd1;
    endfunction

    function automatic void predict_access(input access_t a);
        int               s, w;
        logic [2:0]       f;
        logic             sp;
        logic [TAG_W-1:0] tag_gap;
        logic [3:0]       old_pos;
        s = a.set_index % SETS;
        w = a.way_index;
        if (a.func == FUNC_VICTIM) begin
            expected_ways.push_back(choose_victim(s, a.valid_mask));
            return;
        end
        f = count_tag(s, a.line_address, a.hit_flag);
        sp = 0;
        if (last_miss[s] != 0) begin
            tag_gap = a.line_address > last_miss[s] ? a.line_address - last_miss[s]
                                                    : last_miss[s] - a.line_address;
            sp = tag_gap != 0 && tag_gap <= half_window;
        end
        wfreq[s][w] = f;
        smark[s][w] = sp;
        if (!a.hit_flag) last_miss[s] = a.line_address;
        rrpv[s][w] = (a.hit_flag || f >= retain_thresh || sp) ? 2'd0 : RRPV_TOP;
        old_pos = rpos[s][w];
        for (int k = 0; k < WAYS; k++)
            if (rpos[s][k] < old_pos) rpos[s][k]++;
        rpos[s][w] = 0;
    endfunction

    function automatic access_t make_access(input logic func, input int set, input int way,
                                            input logic [15:0] mask,
                                            input logic [TAG_W-1:0] tag, input logic hit);
        access_t a;
        a.func = func; a.set_index = set[SIDX_W-1:0]; a.way_index = way[3:0];
        a.valid_mask = mask; a.line_address = tag; a.hit_flag = hit;
        return a;
    endfunction

    function automatic logic [TAG_W-1:0] rand_tag();
        return TAG_W'({$urandom(), $urandom()});
    endfunction

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Driver: bursts with random gaps, fed from the pending queue.
    always @(negedge aclk) begin
        access_t a;
        if (aresetn) begin
            if (offer_open) begin
            end else if (pending_words.size() > 0 && (burst_left > 0 || gap_left == 0)) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                burst_left--;
                a = pending_words[0];
                offer_open = 1'b1;
                s_tvalid <= 1'b1;
                s_tdata <= {7'd0, a.line_address, a.valid_mask, a.way_index, a.set_index};
                s_tuser <= {a.hit_flag, a.func};
            end else begin
                if (gap_left > 0) gap_left--;
                s_tvalid <= 1'b0;
            end
            m_tready <= !hold_off && ($urandom_range(0, 3) != 0 || (sent / 200) % 2 == 1);
        end
    end

    // Monitor and watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (s_tvalid && s_tready) begin
                sent++;
                predict_access(pending_words.pop_front());
                offer_open = 1'b0;
            end
            if (m_tvalid && m_tready) begin
                victims_seen++;
                if (expected_ways.size() == 0)
                    report_mismatch("unexpected victim_way", m_tdata[3:0], -1);
                else if (m_tdata[3:0] != expected_ways[0] || m_tdata[7:4] != 0)
                    report_mismatch("victim_way", m_tdata, expected_ways.pop_front());
                else
                    void'(expected_ways.pop_front());
            end
            if (idle_cycles > IDLE_LIMIT) begin
                $display("watchdog: no progress, %0d results outstanding",
                         expected_ways.size());
                $display("freq_spatial_rrip_replacement_tb: errors");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic index, input logic [2:0] value);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {index, 2'b00}; pwdata <= {29'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (index == REG_WINDOW) half_window = value;
        else retain_thresh = value;
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        while ((pending_words.size() > 0 || s_tvalid || expected_ways.size() > 0)
               && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (60) @(posedge aclk);
    endtask

    // A small pool of sets and neighbouring tags keeps the tables and windows busy.
    task automatic queue_random(input int count);
        int               set;
        logic [TAG_W-1:0] base;
        for (int i = 0; i < count; i++) begin
            set = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 5);
            base = TAG_W'((set * 64) + 1);
            if ($urandom_range(0, 9) < 6)
                pending_words.push_back(make_access(FUNC_UPDATE, set, $urandom_range(0, 15),
                    16'($urandom()), ($urandom_range(0, 9) == 0) ? rand_tag()
                        : base + $urandom_range(0, 12), 1'($urandom_range(0, 1))));
            else
                pending_words.push_back(make_access(FUNC_VICTIM, set, $urandom_range(0, 15),
                    ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'hFFFF,
                    rand_tag(), 1'($urandom_range(0, 1))));
        end
    endtask

    initial begin
        for (int s = 0; s < SETS; s++) begin
            fptr[s] = 0; last_miss[s] = 0;
            for (int w = 0; w < WAYS; w++) begin
                rrpv[s][w] = RRPV_TOP; wfreq[s][w] = 0; rpos[s][w] = 4'(w); smark[s][w] = 0;
            end
            for (int e = 0; e < FENT; e++) fval[s][e] = 0;
        end
        half_window = WINDOW_RESET;
        retain_thresh = THRESH_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes of every field, both operations, saturation and spatial cases.
        pending_words.push_back(make_access(FUNC_VICTIM, 0, 0, 16'h0000, '0, 0));
        pending_words.push_back(make_access(FUNC_VICTIM, 2047, 15, 16'h7FFF, '1, 1));
        pending_words.push_back(make_access(FUNC_VICTIM, 7, 0, 16'hFFFF, '0, 0));
        pending_words.push_back(make_access(FUNC_UPDATE, 7, 15, 16'hFFFF, '1, 0));
        pending_words.push_back(make_access(FUNC_UPDATE, 7, 3, 16'h0, '1 - 58'd1, 0));
        for (int i = 0; i < 8; i++)
            pending_words.push_back(make_access(FUNC_UPDATE, 7, 5, 16'h0, 58'd100, 1));
        pending_words.push_back(make_access(FUNC_UPDATE, 7, 6, 16'h0, 58'd100, 0));
        for (int i = 0; i < 9; i++)
            pending_words.push_back(make_access(FUNC_UPDATE, 7, i, 16'h0, 58'd200 + i, 0));
        pending_words.push_back(make_access(FUNC_VICTIM, 7, 0, 16'hFFFF, '0, 0));
        pending_words.push_back(make_access(FUNC_VICTIM, 2047, 0, 16'hFFFF, '0, 0));
        drain();

        write_reg(REG_WINDOW, 3'd0);
        write_reg(REG_THRESH, 3'd7);
        queue_random(400);
        drain();
        write_reg(REG_WINDOW, 3'd7);
        write_reg(REG_THRESH, 3'd0);
        // The receiver holds off for a long stretch while words keep arriving.
        queue_random(400);
        hold_off = 1'b1;
        repeat (300) @(posedge aclk);
        hold_off = 1'b0;
        drain();
        write_reg(REG_WINDOW, 3'd3);
        write_reg(REG_THRESH, 3'd1);
        queue_random(400);
        drain();
        write_reg(REG_WINDOW, WINDOW_RESET);
        write_reg(REG_THRESH, 3'd4);
        queue_random(400);
        drain();

        if (expected_ways.size() > 0)
            report_mismatch("results never delivered", expected_ways.size(), 0);
        $display("Covered %0d input words and %0d victim results over five register settings,",
                 sent, victims_seen);
        $display("including a long result stall that backed up the input.");
        if (errors == 0) begin
            $display("freq_spatial_rrip_replacement_tb: clean");
        end else begin
            $display("freq_spatial_rrip_replacement_tb: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/frsr_pkg.sv
design/frsr_victim_scan.sv
design/freq_spatial_rrip_replacement.sv
verif/freq_spatial_rrip_replacement_tb.sv
